// File: src/prs_pkg.sv
// Shared types, widths and constants for the power rail sequencer.
`default_nettype none

package prs_pkg;

    localparam int MV_W      = 15;
    localparam int LEVEL_W   = 7;
    localparam int UP_W      = LEVEL_W + 1;
    localparam int DELAY_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam int RAMP_STEPS_DEF        = 64;
    localparam int BOOST_SETTLE_MS_DEF   = 500;
    localparam int CHECK24_SETTLE_MS_DEF = 200;
    localparam int CHECK12_SETTLE_MS_DEF = 50;
    localparam int RAMP_UP_STEP_MS_DEF   = 8;
    localparam int RAMP_DOWN_STEP_MS_DEF = 1;

    localparam logic [MV_W-1:0] RAIL12_MIN_RST = MV_W'(10500);
    localparam logic [MV_W-1:0] RAIL12_MAX_RST = MV_W'(13500);
    localparam logic [MV_W-1:0] RAIL24_MIN_RST = MV_W'(21000);
    localparam logic [MV_W-1:0] RAIL24_MAX_RST = MV_W'(27000);
    localparam logic [MV_W-1:0] PRE12_MIN_RST  = MV_W'(11500);
    localparam logic [MV_W-1:0] PRE12_MAX_RST  = MV_W'(12500);
    localparam logic [MV_W-1:0] PRE24_MIN_RST  = MV_W'(7000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOARD_REV  = 3'd0,
        CFG_RAIL12_MIN = 3'd1,
        CFG_RAIL12_MAX = 3'd2,
        CFG_RAIL24_MIN = 3'd3,
        CFG_RAIL24_MAX = 3'd4,
        CFG_PRE12_MIN  = 3'd5,
        CFG_PRE12_MAX  = 3'd6,
        CFG_PRE24_MIN  = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TS_STBY   = 3'd0,
        TS_R0_ON  = 3'd1,
        TS_R0_OFF = 3'd2,
        TS_R1_ON  = 3'd3,
        TS_R1_OFF = 3'd4
    } top_state_t;

    typedef enum logic [1:0] {
        RES_BUSY = 2'd0,
        RES_DONE = 2'd1,
        RES_ERR  = 2'd2
    } seq_res_t;

    // sub-sequence step codes
    localparam logic [2:0] SS_STEP0 = 3'd0;
    localparam logic [2:0] SS_STEP1 = 3'd1;
    localparam logic [2:0] SS_STEP2 = 3'd2;
    localparam logic [2:0] SS_STEP3 = 3'd3;
    localparam logic [2:0] SS_STEP4 = 3'd4;

    typedef struct packed {
        logic            board_rev;
        logic [MV_W-1:0] rail12_min;
        logic [MV_W-1:0] rail12_max;
        logic [MV_W-1:0] rail24_min;
        logic [MV_W-1:0] rail24_max;
        logic [MV_W-1:0] pre12_min;
        logic [MV_W-1:0] pre12_max;
        logic [MV_W-1:0] pre24_min;
    } cfg_t;

    typedef struct packed {
        logic            ms_tick;
        logic [MV_W-1:0] v12_mv;
        logic [MV_W-1:0] v24_mv;
        logic            req_on;
        logic            req_off;
    } in_item_t;

    typedef struct packed {
        logic pg;
        logic up;
        logic poff;
        logic pon;
        logic r24;
        logic r12;
        logic start;
    } status_t;

    typedef struct packed {
        logic               en_24v;
        logic [LEVEL_W-1:0] level_12v;
        logic               level_strobe;
        logic               rail12_on;
        logic               rail24_on;
        logic               powering_on;
        logic               powering_off;
        logic               rails_up;
        logic               power_good;
        logic               starting_up;
        logic               precheck_fail;
        logic               seq_fault;
    } res_t;

endpackage

`default_nettype wire

// File: src/prs_cfg_regs.sv
// Configuration register bank for the power rail sequencer.
`default_nettype none

module prs_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prs_pkg::MV_W-1:0]       cfg_wdata,
    output prs_pkg::cfg_t                       cfg
);

    prs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.board_rev  <= 1'b0;
            cfg_reg.rail12_min <= prs_pkg::RAIL12_MIN_RST;
            cfg_reg.rail12_max <= prs_pkg::RAIL12_MAX_RST;
            cfg_reg.rail24_min <= prs_pkg::RAIL24_MIN_RST;
            cfg_reg.rail24_max <= prs_pkg::RAIL24_MAX_RST;
            cfg_reg.pre12_min  <= prs_pkg::PRE12_MIN_RST;
            cfg_reg.pre12_max  <= prs_pkg::PRE12_MAX_RST;
            cfg_reg.pre24_min  <= prs_pkg::PRE24_MIN_RST;
        end else if (cfg_wr_en) begin
            unique case (prs_pkg::cfg_idx_t'(cfg_index))
                prs_pkg::CFG_BOARD_REV:  cfg_reg.board_rev  <= cfg_wdata[0];
                prs_pkg::CFG_RAIL12_MIN: cfg_reg.rail12_min <= cfg_wdata;
                prs_pkg::CFG_RAIL12_MAX: cfg_reg.rail12_max <= cfg_wdata;
                prs_pkg::CFG_RAIL24_MIN: cfg_reg.rail24_min <= cfg_wdata;
                prs_pkg::CFG_RAIL24_MAX: cfg_reg.rail24_max <= cfg_wdata;
                prs_pkg::CFG_PRE12_MIN:  cfg_reg.pre12_min  <= cfg_wdata;
                prs_pkg::CFG_PRE12_MAX:  cfg_reg.pre12_max  <= cfg_wdata;
                prs_pkg::CFG_PRE24_MIN:  cfg_reg.pre24_min  <= cfg_wdata;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/prs_seq.sv
// Sequencer state and single-pass step logic for the power rail sequencer.
`default_nettype none

module prs_seq #(
    parameter int RAMP_STEPS        = prs_pkg::RAMP_STEPS_DEF,
    parameter int BOOST_SETTLE_MS   = prs_pkg::BOOST_SETTLE_MS_DEF,
    parameter int CHECK24_SETTLE_MS = prs_pkg::CHECK24_SETTLE_MS_DEF,
    parameter int CHECK12_SETTLE_MS = prs_pkg::CHECK12_SETTLE_MS_DEF,
    parameter int RAMP_UP_STEP_MS   = prs_pkg::RAMP_UP_STEP_MS_DEF,
    parameter int RAMP_DOWN_STEP_MS = prs_pkg::RAMP_DOWN_STEP_MS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  prs_pkg::in_item_t  item,
    input  prs_pkg::cfg_t      cfg,
    output prs_pkg::res_t      res
);

    localparam int LW = prs_pkg::LEVEL_W;
    localparam int UW = prs_pkg::UP_W;
    localparam int DW = prs_pkg::DELAY_W;

    localparam logic [UW-1:0] UP_TOP   = UW'(RAMP_STEPS + 1);
    localparam logic [LW-1:0] DN_TOP   = LW'(RAMP_STEPS + 1);
    localparam logic [DW-1:0] D_BOOST  = DW'(BOOST_SETTLE_MS);
    localparam logic [DW-1:0] D_CHK24  = DW'(CHECK24_SETTLE_MS);
    localparam logic [DW-1:0] D_CHK12  = DW'(CHECK12_SETTLE_MS);
    localparam logic [DW-1:0] D_UPSTEP = DW'(RAMP_UP_STEP_MS);
    localparam logic [DW-1:0] D_DNSTEP = DW'(RAMP_DOWN_STEP_MS);

    prs_pkg::top_state_t top_reg, top_next;
    logic [2:0]          sub_reg, sub_next;
    logic                rw_reg, rw_next;
    logic [UW-1:0]       up_reg, up_next;
    logic [LW-1:0]       dn_reg, dn_next;
    logic [DW-1:0]       dly_reg, dly_next;
    logic                on_p_reg, on_p_next;
    logic                off_p_reg, off_p_next;
    prs_pkg::status_t    fl_reg, fl_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic                en_reg, en_next;

    prs_pkg::seq_res_t   seq_res;
    logic                go_on, go_off;
    logic                strobe, pfail, fault;
    logic                in12, in24, pre_bad;
    logic [DW-1:0]       dly_dec;

    // ramp helpers, evaluated from the state at the start of the pass
    logic                ru_rw, ru_wr, ru_done;
    logic [UW-1:0]       ru_up;
    logic [DW-1:0]       ru_dly;
    logic                rd_rw, rd_wr, rd_done;
    logic [LW-1:0]       rd_dn;
    logic [DW-1:0]       rd_dly;

    assign in12 = (item.v12_mv >= cfg.rail12_min) && (item.v12_mv <= cfg.rail12_max);
    assign in24 = (item.v24_mv >= cfg.rail24_min) && (item.v24_mv <= cfg.rail24_max);
    assign pre_bad = cfg.board_rev
        ? ((item.v24_mv < cfg.pre24_min) || (item.v24_mv > cfg.rail24_max))
        : ((item.v12_mv < cfg.pre12_min) || (item.v12_mv > cfg.pre12_max));
    assign dly_dec = (item.ms_tick && (dly_reg != '0)) ? dly_reg - 1'b1 : dly_reg;

    always_comb begin
        ru_rw = rw_reg; ru_wr = 1'b0; ru_done = 1'b0; ru_up = up_reg; ru_dly = dly_dec;
        if (!rw_reg) begin
            if (up_reg <= UP_TOP) begin
                ru_wr  = 1'b1;
                ru_up  = up_reg + 1'b1;
                ru_dly = D_UPSTEP;
                ru_rw  = 1'b1;
            end else begin
                ru_up = '0;
            end
        end else if (dly_dec == '0) begin
            ru_rw = 1'b0;
            if (up_reg > UP_TOP) begin
                ru_up   = '0;
                ru_done = 1'b1;
            end
        end
    end

    always_comb begin
        rd_rw = rw_reg; rd_wr = 1'b0; rd_done = 1'b0; rd_dn = dn_reg; rd_dly = dly_dec;
        if (!rw_reg) begin
            if ((dn_reg != '0) && (dn_reg <= DN_TOP)) begin
                rd_wr  = 1'b1;
                rd_dn  = dn_reg - 1'b1;
                rd_dly = D_DNSTEP;
                rd_rw  = 1'b1;
            end else begin
                rd_dn = DN_TOP;
            end
        end else if (dly_dec == '0) begin
            rd_rw = 1'b0;
            if (dn_reg == '0) begin
                rd_dn   = DN_TOP;
                rd_done = 1'b1;
            end
        end
    end

    // datapath side of one pass
    always_comb begin
        sub_next   = sub_reg;
        rw_next    = rw_reg;
        up_next    = up_reg;
        dn_next    = dn_reg;
        dly_next   = dly_dec;
        on_p_next  = on_p_reg | item.req_on;
        off_p_next = off_p_reg | item.req_off;
        fl_next    = fl_reg;
        lvl_next   = lvl_reg;
        en_next    = en_reg;
        seq_res    = prs_pkg::RES_BUSY;
        go_on      = 1'b0;
        go_off     = 1'b0;
        strobe     = 1'b0;
        pfail      = 1'b0;
        fault      = 1'b0;

        if (!fl_reg.start) begin
            fl_next.pg = fl_reg.r12 && in12 && fl_reg.r24 && in24;
        end

        unique case (top_reg)
            prs_pkg::TS_STBY: begin
                if (on_p_next) begin
                    if (pre_bad) begin
                        on_p_next     = 1'b0;
                        fl_next.start = 1'b0;
                        pfail         = 1'b1;
                    end else begin
                        fl_next.pon  = 1'b1;
                        fl_next.poff = 1'b0;
                        go_on        = 1'b1;
                    end
                end else if (off_p_next) begin
                    fl_next.pon  = 1'b0;
                    fl_next.poff = 1'b1;
                    go_off       = 1'b1;
                end
            end
            prs_pkg::TS_R0_ON: begin
                fl_next.pon  = 1'b1;
                fl_next.poff = 1'b0;
                unique case (sub_reg)
                    prs_pkg::SS_STEP0: begin
                        rw_next  = ru_rw;
                        up_next  = ru_up;
                        dly_next = ru_dly;
                        if (ru_wr) begin
                            lvl_next = up_reg[LW-1:0];
                            strobe   = 1'b1;
                        end
                        if (ru_done) begin
                            fl_next.r12 = 1'b1;
                            dly_next    = D_BOOST;
                            sub_next    = prs_pkg::SS_STEP1;
                        end
                    end
                    prs_pkg::SS_STEP1: begin
                        if (dly_dec == '0) begin
                            en_next     = 1'b1;
                            fl_next.r24 = 1'b1;
                            dly_next    = D_BOOST;
                            sub_next    = prs_pkg::SS_STEP2;
                        end
                    end
                    prs_pkg::SS_STEP2: begin
                        if (dly_dec == '0) begin
                            sub_next = prs_pkg::SS_STEP0;
                            seq_res  = prs_pkg::RES_DONE;
                        end
                    end
                    default: begin
                        sub_next = prs_pkg::SS_STEP0;
                        fault    = 1'b1;
                        seq_res  = prs_pkg::RES_ERR;
                    end
                endcase
            end
            prs_pkg::TS_R1_ON: begin
                fl_next.pon  = 1'b1;
                fl_next.poff = 1'b0;
                unique case (sub_reg)
                    prs_pkg::SS_STEP0: begin
                        en_next  = 1'b1;
                        dly_next = D_CHK24;
                        sub_next = prs_pkg::SS_STEP1;
                    end
                    prs_pkg::SS_STEP1: begin
                        if (dly_dec == '0) begin
                            if (in24) begin
                                fl_next.r24 = 1'b1;
                                sub_next    = prs_pkg::SS_STEP2;
                            end else begin
                                en_next     = 1'b0;
                                fl_next.r24 = 1'b0;
                                sub_next    = prs_pkg::SS_STEP0;
                                fault       = 1'b1;
                                seq_res     = prs_pkg::RES_ERR;
                            end
                        end
                    end
                    prs_pkg::SS_STEP2: begin
                        rw_next  = ru_rw;
                        up_next  = ru_up;
                        dly_next = ru_dly;
                        if (ru_wr) begin
                            lvl_next = up_reg[LW-1:0];
                            strobe   = 1'b1;
                        end
                        if (ru_done) begin
                            dly_next = D_CHK12;
                            sub_next = prs_pkg::SS_STEP3;
                        end
                    end
                    prs_pkg::SS_STEP3: begin
                        if (dly_dec == '0) begin
                            if (in12) begin
                                fl_next.r12 = 1'b1;
                                sub_next    = prs_pkg::SS_STEP0;
                                seq_res     = prs_pkg::RES_DONE;
                            end else begin
                                fl_next.r12 = 1'b0;
                                fault       = 1'b1;
                                sub_next    = prs_pkg::SS_STEP4;
                            end
                        end
                    end
                    prs_pkg::SS_STEP4: begin
                        rw_next  = rd_rw;
                        dn_next  = rd_dn;
                        dly_next = rd_dly;
                        if (rd_wr) begin
                            lvl_next = dn_reg;
                            strobe   = 1'b1;
                        end
                        if (rd_done) begin
                            fl_next.r12 = 1'b0;
                            en_next     = 1'b0;
                            fl_next.r24 = 1'b0;
                            sub_next    = prs_pkg::SS_STEP0;
                            seq_res     = prs_pkg::RES_ERR;
                        end
                    end
                    default: begin
                        sub_next = prs_pkg::SS_STEP0;
                        fault    = 1'b1;
                        seq_res  = prs_pkg::RES_ERR;
                    end
                endcase
            end
            prs_pkg::TS_R0_OFF: begin
                fl_next.pon  = 1'b0;
                fl_next.poff = 1'b1;
                unique case (sub_reg)
                    prs_pkg::SS_STEP0: begin
                        en_next     = 1'b0;
                        fl_next.r24 = 1'b0;
                        sub_next    = prs_pkg::SS_STEP1;
                    end
                    prs_pkg::SS_STEP1: begin
                        rw_next  = rd_rw;
                        dn_next  = rd_dn;
                        dly_next = rd_dly;
                        if (rd_wr) begin
                            lvl_next = dn_reg;
                            strobe   = 1'b1;
                        end
                        if (rd_done) begin
                            fl_next.r12 = 1'b0;
                            sub_next    = prs_pkg::SS_STEP0;
                            seq_res     = prs_pkg::RES_DONE;
                        end
                    end
                    default: begin
                        sub_next = prs_pkg::SS_STEP0;
                        seq_res  = prs_pkg::RES_DONE;
                    end
                endcase
                if (seq_res == prs_pkg::RES_DONE) begin
                    fl_next.up = 1'b0;
                    off_p_next = 1'b0;
                end
            end
            prs_pkg::TS_R1_OFF: begin
                fl_next.pon  = 1'b0;
                fl_next.poff = 1'b1;
                rw_next  = rd_rw;
                dn_next  = rd_dn;
                dly_next = rd_dly;
                if (rd_wr) begin
                    lvl_next = dn_reg;
                    strobe   = 1'b1;
                end
                if (rd_done) begin
                    fl_next.r12  = 1'b0;
                    en_next      = 1'b0;
                    fl_next.r24  = 1'b0;
                    fl_next.up   = 1'b0;
                    off_p_next   = 1'b0;
                    fl_next.pon  = 1'b0;
                    fl_next.poff = 1'b0;
                    seq_res      = prs_pkg::RES_DONE;
                end
            end
            default: begin
            end
        endcase

        // outcome of a power-up sequence
        if ((top_reg == prs_pkg::TS_R0_ON) || (top_reg == prs_pkg::TS_R1_ON)) begin
            if (seq_res == prs_pkg::RES_ERR) begin
                fl_next.up    = 1'b0;
                on_p_next     = 1'b0;
                fl_next.pon   = 1'b0;
                fl_next.poff  = 1'b1;
                fl_next.start = 1'b0;
            end else if (seq_res == prs_pkg::RES_DONE) begin
                fl_next.up    = 1'b1;
                on_p_next     = 1'b0;
                fl_next.pon   = 1'b0;
                fl_next.poff  = 1'b0;
                fl_next.start = 1'b0;
            end
        end
    end

    // top-level state transitions
    always_comb begin
        top_next = top_reg;
        unique case (top_reg)
            prs_pkg::TS_STBY: begin
                if (go_on) begin
                    top_next = cfg.board_rev ? prs_pkg::TS_R1_ON : prs_pkg::TS_R0_ON;
                end else if (go_off) begin
                    top_next = cfg.board_rev ? prs_pkg::TS_R1_OFF : prs_pkg::TS_R0_OFF;
                end
            end
            prs_pkg::TS_R0_ON: begin
                if (seq_res == prs_pkg::RES_ERR) begin
                    top_next = prs_pkg::TS_R0_OFF;
                end else if (seq_res == prs_pkg::RES_DONE) begin
                    top_next = prs_pkg::TS_STBY;
                end
            end
            prs_pkg::TS_R1_ON: begin
                if (seq_res == prs_pkg::RES_ERR) begin
                    top_next = prs_pkg::TS_R1_OFF;
                end else if (seq_res == prs_pkg::RES_DONE) begin
                    top_next = prs_pkg::TS_STBY;
                end
            end
            prs_pkg::TS_R0_OFF, prs_pkg::TS_R1_OFF: begin
                if (seq_res == prs_pkg::RES_DONE) begin
                    top_next = prs_pkg::TS_STBY;
                end
            end
            default: top_next = prs_pkg::TS_STBY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= prs_pkg::TS_STBY;
            sub_reg   <= prs_pkg::SS_STEP0;
            rw_reg    <= 1'b0;
            up_reg    <= '0;
            dn_reg    <= DN_TOP;
            dly_reg   <= '0;
            on_p_reg  <= 1'b1;
            off_p_reg <= 1'b0;
            fl_reg    <= '{start: 1'b1, default: 1'b0};
            lvl_reg   <= '0;
            en_reg    <= 1'b0;
        end else if (advance) begin
            top_reg   <= top_next;
            sub_reg   <= sub_next;
            rw_reg    <= rw_next;
            up_reg    <= up_next;
            dn_reg    <= dn_next;
            dly_reg   <= dly_next;
            on_p_reg  <= on_p_next;
            off_p_reg <= off_p_next;
            fl_reg    <= fl_next;
            lvl_reg   <= lvl_next;
            en_reg    <= en_next;
        end
    end

    always_comb begin
        res.en_24v        = en_next;
        res.level_12v     = lvl_next;
        res.level_strobe  = strobe;
        res.rail12_on     = fl_next.r12;
        res.rail24_on     = fl_next.r24;
        res.powering_on   = fl_next.pon;
        res.powering_off  = fl_next.poff;
        res.rails_up      = fl_next.up;
        res.power_good    = fl_next.pg;
        res.starting_up   = fl_next.start;
        res.precheck_fail = pfail;
        res.seq_fault     = fault;
    end

endmodule

`default_nettype wire

// File: src/power_rail_sequencer.sv
// Top level of the power rail sequencer: input register, step logic, result register.
//
// Each slave-side transaction is one pass of the rail control loop: a millisecond
// tick, the 12 V and 24 V samples in mV and on/off request pulses. Every accepted
// transaction yields exactly one master-side transaction with the enable drive,
// the 12 V soft-start level and strobe, and the rail and power-good status.
// Configuration (board revision and voltage windows) is written through the
// cfg_* port, one register per cycle in which cfg_wr_en is high; the user must
// write it only while idle, as the block itself does not enforce this. An accepted
// transaction is registered in the input stage, then stepped through the sequencer
// into the result register once that is free or taken, and held on the master side.
// Throughput: one transaction per cycle while results are taken; the sequencer state
// feeds back through one pass of compare-and-select logic, which sets this figure.
// Reset (aresetn low, synchronous) clears both stages, loads the default
// configuration and arms a pending power-up request.
// When the master side stalls, the result holds and the input stage fills; the
// slave side then deasserts s_tready until the result is taken.
`default_nettype none

module power_rail_sequencer #(
    parameter int RAMP_STEPS        = prs_pkg::RAMP_STEPS_DEF,
    parameter int BOOST_SETTLE_MS   = prs_pkg::BOOST_SETTLE_MS_DEF,
    parameter int CHECK24_SETTLE_MS = prs_pkg::CHECK24_SETTLE_MS_DEF,
    parameter int CHECK12_SETTLE_MS = prs_pkg::CHECK12_SETTLE_MS_DEF,
    parameter int RAMP_UP_STEP_MS   = prs_pkg::RAMP_UP_STEP_MS_DEF,
    parameter int RAMP_DOWN_STEP_MS = prs_pkg::RAMP_DOWN_STEP_MS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [prs_pkg::MV_W-1:0]      cfg_wdata,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // ms_tick[0], v12_mv[15:1], v24_mv[30:16], req_on[31], req_off[32], zero fill
    input  wire logic [prs_pkg::S_TDATA_W-1:0] s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // en_24v[0], level_12v[7:1], level_strobe[8], rail12_on[9], rail24_on[10],
    // powering_on[11], powering_off[12], rails_up[13], power_good[14],
    // starting_up[15], precheck_fail[16], seq_fault[17], zero fill
    output      logic [prs_pkg::M_TDATA_W-1:0] m_tdata
);

    prs_pkg::cfg_t     cfg;
    prs_pkg::in_item_t in_reg;
    prs_pkg::res_t     res;
    prs_pkg::res_t     out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.ms_tick <= s_tdata[0];
            in_reg.v12_mv  <= s_tdata[15:1];
            in_reg.v24_mv  <= s_tdata[30:16];
            in_reg.req_on  <= s_tdata[31];
            in_reg.req_off <= s_tdata[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    prs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    prs_seq #(
        .RAMP_STEPS        (RAMP_STEPS),
        .BOOST_SETTLE_MS   (BOOST_SETTLE_MS),
        .CHECK24_SETTLE_MS (CHECK24_SETTLE_MS),
        .CHECK12_SETTLE_MS (CHECK12_SETTLE_MS),
        .RAMP_UP_STEP_MS   (RAMP_UP_STEP_MS),
        .RAMP_DOWN_STEP_MS (RAMP_DOWN_STEP_MS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_reg.seq_fault,
                       out_reg.precheck_fail,
                       out_reg.starting_up,
                       out_reg.power_good,
                       out_reg.rails_up,
                       out_reg.powering_off,
                       out_reg.powering_on,
                       out_reg.rail24_on,
                       out_reg.rail12_on,
                       out_reg.level_strobe,
                       out_reg.level_12v,
                       out_reg.en_24v};

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for power_rail_sequencer: directed table, then random passes.
module testbench;

    localparam int RAMP_TOP    = prs_pkg::RAMP_STEPS_DEF + 1;
    localparam int MV_MAX      = (1 << prs_pkg::MV_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PLAN_LEN    = 16;

    typedef struct packed {
        logic                        tick;
        logic [prs_pkg::MV_W-1:0]    v12;
        logic [prs_pkg::MV_W-1:0]    v24;
        logic [1:0]                  reqs;   // req_on, req_off
        logic                        pin;
        logic [prs_pkg::LEVEL_W-1:0] lvl;
        logic [10:0]                 flags;  // en stb r12 r24 pon poff up pg start pfail fault
    } plan_row_t;

    typedef struct {
        bit            pinned;
        prs_pkg::res_t want;
    } pin_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        {1'b0, 15'd0,     15'd0,     2'b00, 1'b1, 7'd0, 11'b00000000010},
        {1'b1, 15'd32767, 15'd32767, 2'b10, 1'b1, 7'd0, 11'b00000000010},
        {1'b1, 15'd11499, 15'd0,     2'b10, 1'b1, 7'd0, 11'b00000000010},
        {1'b0, 15'd12501, 15'd32767, 2'b10, 1'b1, 7'd0, 11'b00000000010},
        {1'b0, 15'd11500, 15'd0,     2'b11, 1'b1, 7'd0, 11'b00001000000},
        {1'b0, 15'd0,     15'd32767, 2'b00, 1'b1, 7'd0, 11'b01001000000},
        {1'b1, 15'd32767, 15'd0,     2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'h5555,  15'h2AAA,  2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'h2AAA,  15'h5555,  2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd12000, 15'd24000, 2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd0,     15'd0,     2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd32767, 15'd32767, 2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd10500, 15'd13500, 2'b00, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd21000, 15'd27000, 2'b00, 1'b0, 7'd0, 11'b0},
        {1'b0, 15'd12000, 15'd24000, 2'b10, 1'b0, 7'd0, 11'b0},
        {1'b1, 15'd0,     15'd0,     2'b01, 1'b0, 7'd0, 11'b0}
    };

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [prs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [prs_pkg::MV_W-1:0]      cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [prs_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b1;
    logic [prs_pkg::M_TDATA_W-1:0] m_tdata;

    int            errors     = 0;
    int            src_idle   = 0;
    int            sink_stall = 0;
    bit            hold_go    = 1'b0;
    bit            hold_done  = 1'b0;
    int            hold_left  = 0;
    prs_pkg::res_t pending_status [$];
    pin_t          pinned_q [$];

    // sequencer mirror
    prs_pkg::cfg_t               win;
    prs_pkg::top_state_t         seq_top;
    logic [2:0]                  seq_step;
    bit                          ramp_busy;
    int                          rise_lvl;
    int                          fall_lvl;
    int                          settle;
    bit                          on_req;
    bit                          off_req;
    prs_pkg::status_t            st;
    logic [prs_pkg::LEVEL_W-1:0] lvl_out;
    bit                          en24;
    bit                          strobe_now;
    bit                          prefail_now;
    bit                          fault_now;
    int                          s12;
    int                          s24;

    power_rail_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void reset_mirror();
        win.board_rev  = 1'b0;
        win.rail12_min = prs_pkg::RAIL12_MIN_RST;
        win.rail12_max = prs_pkg::RAIL12_MAX_RST;
        win.rail24_min = prs_pkg::RAIL24_MIN_RST;
        win.rail24_max = prs_pkg::RAIL24_MAX_RST;
        win.pre12_min  = prs_pkg::PRE12_MIN_RST;
        win.pre12_max  = prs_pkg::PRE12_MAX_RST;
        win.pre24_min  = prs_pkg::PRE24_MIN_RST;
        seq_top   = prs_pkg::TS_STBY;
        seq_step  = prs_pkg::SS_STEP0;
        ramp_busy = 1'b0;
        rise_lvl  = 0;
        fall_lvl  = RAMP_TOP;
        settle    = 0;
        on_req    = 1'b1;
        off_req   = 1'b0;
        st        = '0;
        st.start  = 1'b1;
        lvl_out   = '0;
        en24      = 1'b0;
    endfunction

    function automatic bit good12();
        return s12 >= win.rail12_min && s12 <= win.rail12_max;
    endfunction

    function automatic bit good24();
        return s24 >= win.rail24_min && s24 <= win.rail24_max;
    endfunction

    function automatic void put_level(int v);
        lvl_out    = prs_pkg::LEVEL_W'(v);
        strobe_now = 1'b1;
    endfunction

    function automatic bit ramp_rise();
        if (!ramp_busy) begin
            if (rise_lvl <= RAMP_TOP) begin
                put_level(rise_lvl);
                rise_lvl++;
                settle    = prs_pkg::RAMP_UP_STEP_MS_DEF;
                ramp_busy = 1'b1;
            end else begin
                rise_lvl = 0;
            end
            return 1'b0;
        end
        if (settle == 0) begin
            ramp_busy = 1'b0;
            if (rise_lvl > RAMP_TOP) begin
                rise_lvl = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit ramp_fall();
        if (!ramp_busy) begin
            if (fall_lvl > 0 && fall_lvl <= RAMP_TOP) begin
                put_level(fall_lvl);
                fall_lvl--;
                settle    = prs_pkg::RAMP_DOWN_STEP_MS_DEF;
                ramp_busy = 1'b1;
            end else begin
                fall_lvl = RAMP_TOP;
            end
            return 1'b0;
        end
        if (settle == 0) begin
            ramp_busy = 1'b0;
            if (fall_lvl == 0) begin
                fall_lvl = RAMP_TOP;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic prs_pkg::seq_res_t r0_up();
        prs_pkg::seq_res_t res;
        res = prs_pkg::RES_BUSY;
        case (seq_step)
            prs_pkg::SS_STEP0: begin
                if (ramp_rise()) begin
                    st.r12   = 1'b1;
                    settle   = prs_pkg::BOOST_SETTLE_MS_DEF;
                    seq_step = prs_pkg::SS_STEP1;
                end
            end
            prs_pkg::SS_STEP1: begin
                if (settle == 0) begin
                    en24     = 1'b1;
                    st.r24   = 1'b1;
                    settle   = prs_pkg::BOOST_SETTLE_MS_DEF;
                    seq_step = prs_pkg::SS_STEP2;
                end
            end
            prs_pkg::SS_STEP2: begin
                if (settle == 0) begin
                    seq_step = prs_pkg::SS_STEP0;
                    res      = prs_pkg::RES_DONE;
                end
            end
            default: begin
                seq_step  = prs_pkg::SS_STEP0;
                fault_now = 1'b1;
                res       = prs_pkg::RES_ERR;
            end
        endcase
        return res;
    endfunction

    function automatic prs_pkg::seq_res_t r0_down();
        prs_pkg::seq_res_t res;
        res = prs_pkg::RES_BUSY;
        case (seq_step)
            prs_pkg::SS_STEP0: begin
                en24     = 1'b0;
                st.r24   = 1'b0;
                seq_step = prs_pkg::SS_STEP1;
            end
            prs_pkg::SS_STEP1: begin
                if (ramp_fall()) begin
                    st.r12   = 1'b0;
                    seq_step = prs_pkg::SS_STEP0;
                    res      = prs_pkg::RES_DONE;
                end
            end
            default: begin
                seq_step = prs_pkg::SS_STEP0;
                res      = prs_pkg::RES_DONE;
            end
        endcase
        return res;
    endfunction

    function automatic prs_pkg::seq_res_t r1_up();
        prs_pkg::seq_res_t res;
        res = prs_pkg::RES_BUSY;
        case (seq_step)
            prs_pkg::SS_STEP0: begin
                en24     = 1'b1;
                settle   = prs_pkg::CHECK24_SETTLE_MS_DEF;
                seq_step = prs_pkg::SS_STEP1;
            end
            prs_pkg::SS_STEP1: begin
                if (settle == 0) begin
                    if (good24()) begin
                        st.r24   = 1'b1;
                        seq_step = prs_pkg::SS_STEP2;
                    end else begin
                        en24      = 1'b0;
                        st.r24    = 1'b0;
                        seq_step  = prs_pkg::SS_STEP0;
                        fault_now = 1'b1;
                        res       = prs_pkg::RES_ERR;
                    end
                end
            end
            prs_pkg::SS_STEP2: begin
                if (ramp_rise()) begin
                    settle   = prs_pkg::CHECK12_SETTLE_MS_DEF;
                    seq_step = prs_pkg::SS_STEP3;
                end
            end
            prs_pkg::SS_STEP3: begin
                if (settle == 0) begin
                    if (good12()) begin
                        st.r12   = 1'b1;
                        seq_step = prs_pkg::SS_STEP0;
                        res      = prs_pkg::RES_DONE;
                    end else begin
                        st.r12    = 1'b0;
                        fault_now = 1'b1;
                        seq_step  = prs_pkg::SS_STEP4;
                    end
                end
            end
            prs_pkg::SS_STEP4: begin
                if (ramp_fall()) begin
                    st.r12   = 1'b0;
                    en24     = 1'b0;
                    st.r24   = 1'b0;
                    seq_step = prs_pkg::SS_STEP0;
                    res      = prs_pkg::RES_ERR;
                end
            end
            default: begin
                seq_step  = prs_pkg::SS_STEP0;
                fault_now = 1'b1;
                res       = prs_pkg::RES_ERR;
            end
        endcase
        return res;
    endfunction

    function automatic void up_outcome(prs_pkg::seq_res_t res,
                                       prs_pkg::top_state_t off_state);
        if (res == prs_pkg::RES_ERR) begin
            st.up    = 1'b0;
            on_req   = 1'b0;
            st.pon   = 1'b0;
            st.poff  = 1'b1;
            st.start = 1'b0;
            seq_top  = off_state;
        end else if (res == prs_pkg::RES_DONE) begin
            st.up    = 1'b1;
            on_req   = 1'b0;
            st.pon   = 1'b0;
            st.poff  = 1'b0;
            st.start = 1'b0;
            seq_top  = prs_pkg::TS_STBY;
        end
    endfunction

    function automatic prs_pkg::res_t step_rails(prs_pkg::in_item_t it);
        bit            bad;
        prs_pkg::res_t r;
        strobe_now  = 1'b0;
        prefail_now = 1'b0;
        fault_now   = 1'b0;
        s12 = it.v12_mv;
        s24 = it.v24_mv;
        if (it.req_on) on_req = 1'b1;
        if (it.req_off) off_req = 1'b1;
        if (it.ms_tick && settle > 0) settle--;
        if (!st.start) st.pg = st.r12 && good12() && st.r24 && good24();
        case (seq_top)
            prs_pkg::TS_STBY: begin
                if (on_req) begin
                    if (win.board_rev) bad = s24 < win.pre24_min || s24 > win.rail24_max;
                    else bad = s12 < win.pre12_min || s12 > win.pre12_max;
                    if (bad) begin
                        on_req      = 1'b0;
                        st.start    = 1'b0;
                        prefail_now = 1'b1;
                    end else begin
                        st.pon  = 1'b1;
                        st.poff = 1'b0;
                        seq_top = win.board_rev ? prs_pkg::TS_R1_ON : prs_pkg::TS_R0_ON;
                    end
                end else if (off_req) begin
                    st.pon  = 1'b0;
                    st.poff = 1'b1;
                    seq_top = win.board_rev ? prs_pkg::TS_R1_OFF : prs_pkg::TS_R0_OFF;
                end
            end
            prs_pkg::TS_R0_ON: begin
                st.pon  = 1'b1;
                st.poff = 1'b0;
                up_outcome(r0_up(), prs_pkg::TS_R0_OFF);
            end
            prs_pkg::TS_R1_ON: begin
                st.pon  = 1'b1;
                st.poff = 1'b0;
                up_outcome(r1_up(), prs_pkg::TS_R1_OFF);
            end
            prs_pkg::TS_R0_OFF: begin
                st.pon  = 1'b0;
                st.poff = 1'b1;
                if (r0_down() == prs_pkg::RES_DONE) begin
                    st.up   = 1'b0;
                    off_req = 1'b0;
                    seq_top = prs_pkg::TS_STBY;
                end
            end
            prs_pkg::TS_R1_OFF: begin
                st.pon  = 1'b0;
                st.poff = 1'b1;
                if (ramp_fall()) begin
                    st.r12  = 1'b0;
                    en24    = 1'b0;
                    st.r24  = 1'b0;
                    st.up   = 1'b0;
                    off_req = 1'b0;
                    st.poff = 1'b0;
                    seq_top = prs_pkg::TS_STBY;
                end
            end
            default: seq_top = prs_pkg::TS_STBY;
        endcase
        r.en_24v        = en24;
        r.level_12v     = lvl_out;
        r.level_strobe  = strobe_now;
        r.rail12_on     = st.r12;
        r.rail24_on     = st.r24;
        r.powering_on   = st.pon;
        r.powering_off  = st.poff;
        r.rails_up      = st.up;
        r.power_good    = st.pg;
        r.starting_up   = st.start;
        r.precheck_fail = prefail_now;
        r.seq_fault     = fault_now;
        return r;
    endfunction

    function automatic logic [prs_pkg::MV_W-1:0] pick_mv(int lo, int hi);
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (lo > hi && sel < 85) sel = 85;
        if (sel < 70) begin
            v = $urandom_range(hi, lo);
        end else if (sel < 85) begin
            case ($urandom_range(0, 3))
                0: v = lo - 1;
                1: v = lo;
                2: v = hi;
                default: v = hi + 1;
            endcase
        end else if (sel < 93) begin
            v = $urandom_range(0, MV_MAX);
        end else begin
            v = $urandom_range(0, 1) ? MV_MAX : 0;
        end
        if (v < 0) v = 0;
        if (v > MV_MAX) v = MV_MAX;
        return prs_pkg::MV_W'(v);
    endfunction

    function automatic prs_pkg::in_item_t rand_pass();
        prs_pkg::in_item_t it;
        it.ms_tick = ($urandom_range(0, 99) < 94);
        if (win.board_rev) begin
            it.v12_mv = pick_mv(win.rail12_min, win.rail12_max);
            it.v24_mv = $urandom_range(0, 1) ? pick_mv(win.pre24_min, win.rail24_max)
                                             : pick_mv(win.rail24_min, win.rail24_max);
        end else begin
            it.v12_mv = $urandom_range(0, 1) ? pick_mv(win.pre12_min, win.pre12_max)
                                             : pick_mv(win.rail12_min, win.rail12_max);
            it.v24_mv = pick_mv(win.rail24_min, win.rail24_max);
        end
        it.req_on  = ($urandom_range(0, 99) < 4);
        it.req_off = ($urandom_range(0, 99) < 3);
        return it;
    endfunction

    function automatic void cmp_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            errors++;
        end
    endfunction

    task automatic send_pass(input prs_pkg::in_item_t it, input bit pinned,
                             input prs_pkg::res_t want);
        pin_t p;
        p.pinned = pinned;
        p.want   = want;
        while ($urandom_range(0, 99) < src_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(prs_pkg::S_TDATA_W-33){1'b0}}, it.req_off, it.req_on, it.v24_mv,
                     it.v12_mv, it.ms_tick};
        pinned_q.push_back(p);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    task automatic set_reg(input prs_pkg::cfg_idx_t idx, input logic [prs_pkg::MV_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        case (idx)
            prs_pkg::CFG_BOARD_REV:  win.board_rev  = v[0];
            prs_pkg::CFG_RAIL12_MIN: win.rail12_min = v;
            prs_pkg::CFG_RAIL12_MAX: win.rail12_max = v;
            prs_pkg::CFG_RAIL24_MIN: win.rail24_min = v;
            prs_pkg::CFG_RAIL24_MAX: win.rail24_max = v;
            prs_pkg::CFG_PRE12_MIN:  win.pre12_min  = v;
            prs_pkg::CFG_PRE12_MAX:  win.pre12_max  = v;
            prs_pkg::CFG_PRE24_MIN:  win.pre24_min  = v;
        endcase
    endtask

    task automatic load_cfg(input logic rev, input int r12lo, input int r12hi,
                            input int r24lo, input int r24hi, input int p12lo,
                            input int p12hi, input int p24lo);
        set_reg(prs_pkg::CFG_BOARD_REV, prs_pkg::MV_W'(rev));
        set_reg(prs_pkg::CFG_RAIL12_MIN, prs_pkg::MV_W'(r12lo));
        set_reg(prs_pkg::CFG_RAIL12_MAX, prs_pkg::MV_W'(r12hi));
        set_reg(prs_pkg::CFG_RAIL24_MIN, prs_pkg::MV_W'(r24lo));
        set_reg(prs_pkg::CFG_RAIL24_MAX, prs_pkg::MV_W'(r24hi));
        set_reg(prs_pkg::CFG_PRE12_MIN, prs_pkg::MV_W'(p12lo));
        set_reg(prs_pkg::CFG_PRE12_MAX, prs_pkg::MV_W'(p12hi));
        set_reg(prs_pkg::CFG_PRE24_MIN, prs_pkg::MV_W'(p24lo));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int idle, input int stall,
                             input bit squeeze);
        src_idle   = idle;
        sink_stall = stall;
        for (int i = 0; i < count; i++) begin
            if (squeeze && i == 200) hold_go = 1'b1;
            send_pass(rand_pass(), 1'b0, '0);
        end
        drain();
    endtask

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    always @(posedge aclk) begin : scoreboard
        prs_pkg::res_t     want;
        prs_pkg::res_t     got;
        pin_t              pin;
        prs_pkg::in_item_t seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[7:1], m_tdata[8], m_tdata[9], m_tdata[10],
                       m_tdata[11], m_tdata[12], m_tdata[13], m_tdata[14], m_tdata[15],
                       m_tdata[16], m_tdata[17]};
                if (pending_status.size() == 0) begin
                    $error("status transaction with none expected");
                    errors++;
                end else begin
                    want = pending_status.pop_front();
                    cmp_field("en_24v", want.en_24v, got.en_24v);
                    cmp_field("level_12v", want.level_12v, got.level_12v);
                    cmp_field("level_strobe", want.level_strobe, got.level_strobe);
                    cmp_field("rail12_on", want.rail12_on, got.rail12_on);
                    cmp_field("rail24_on", want.rail24_on, got.rail24_on);
                    cmp_field("powering_on", want.powering_on, got.powering_on);
                    cmp_field("powering_off", want.powering_off, got.powering_off);
                    cmp_field("rails_up", want.rails_up, got.rails_up);
                    cmp_field("power_good", want.power_good, got.power_good);
                    cmp_field("starting_up", want.starting_up, got.starting_up);
                    cmp_field("precheck_fail", want.precheck_fail, got.precheck_fail);
                    cmp_field("seq_fault", want.seq_fault, got.seq_fault);
                end
            end
            if (s_tvalid && s_tready) begin
                seen = {s_tdata[0], s_tdata[15:1], s_tdata[30:16], s_tdata[31], s_tdata[32]};
                pin  = pinned_q.pop_front();
                want = step_rails(seen);
                pending_status.push_back(pin.pinned ? pin.want : want);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("power_rail_sequencer regression: fail");
            $finish;
        end
    end

    initial begin
        reset_mirror();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            send_pass({PLAN[i].tick, PLAN[i].v12, PLAN[i].v24, PLAN[i].reqs}, PLAN[i].pin,
                      {PLAN[i].flags[10], PLAN[i].lvl, PLAN[i].flags[9:0]});
        end
        drain();

        load_cfg(1'b0, 10500, 13500, 21000, 27000, 11500, 12500, 7000);
        run_phase(1000, 0, 0, 1'b1);
        load_cfg(1'b1, 10500, 13500, 21000, 27000, 11500, 12500, 7000);
        run_phase(350, 48, 0, 1'b0);
        load_cfg(1'b1, 0, MV_MAX, 0, MV_MAX, 11500, 12500, MV_MAX);
        run_phase(250, 0, 48, 1'b0);
        load_cfg(1'b0, MV_MAX, 0, MV_MAX, 0, 0, MV_MAX, 0);
        run_phase(230, 17, 17, 1'b0);

        sink_stall = 0;
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("power_rail_sequencer regression: pass");
        end else begin
            $display("power_rail_sequencer regression: fail");
        end
        $finish;
    end

endmodule
